### rtl/core/disjoint_interval_set_engine_macros.svh
// Assertion shorthands shared by the interval set engine RTL.
`ifndef DISJOINT_INTERVAL_SET_ENGINE_MACROS_SVH
`define DISJOINT_INTERVAL_SET_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DISE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DISE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dise_pkg.sv
`timescale 1ns / 1ps
package dise_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_FIND   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_EMIT2,
        ST_TAIL,
        ST_DONE
    } t_state;

endpackage

### rtl/core/dise_ram.sv
`timescale 1ns / 1ps
module dise_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

### rtl/core/disjoint_interval_set_engine.sv
`timescale 1ns / 1ps
// Sorted table of disjoint, non-touching closed intervals with insert (merge),
// erase (trim or split), find and clear commands, one transaction at a time.
// The table lives in two RAM banks: a command reads the live bank one entry
// at a time, writes the rebuilt table into the other bank, and on success
// swaps the banks, so a full or invalid command leaves the table as it was.
// Find stops at the first hit; clear and an insert or erase range with upper
// below lower go straight to the result. o_stall stays high from acceptance
// until the result transaction is taken. Bounds are compared one bit wider
// than VALUE_BITS so that lower-1 and upper+1 never wrap.
`include "disjoint_interval_set_engine_macros.svh"
module disjoint_interval_set_engine #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    input  logic signed [31:0] i_search_key,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic               o_hit,
    output logic signed [31:0] o_hit_low,
    output logic signed [31:0] o_hit_high
);

    import dise_pkg::*;

    localparam int W  = VALUE_BITS + 1;
    localparam int AW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);

    // Control state.
    t_state            r_state, n_state;
    logic [NW-1:0]     r_count, n_count;
    logic              r_bank,  n_bank;
    // Per-command working state.
    t_op               r_op,     n_op;
    logic [NW-1:0]     r_i,      n_i;
    logic [NW-1:0]     r_n,      n_n;
    logic              r_placed, n_placed;
    logic signed [W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic signed [W-1:0] r_p2_lo, n_p2_lo, r_p2_hi, n_p2_hi;
    // Result register.
    t_status           r_status, n_status;
    logic              r_hit,    n_hit;
    logic signed [W-1:0] r_hlo, n_hlo, r_hhi, n_hhi;

    // Input conversion to VALUE_BITS two's complement.
    logic [VALUE_BITS-1:0] in_lo, in_hi, in_key;
    logic signed [W-1:0]   ext_lo, ext_hi, ext_key;

    generate
        if (VALUE_BITS <= 32) begin : g_narrow
            assign in_lo  = i_range_low[VALUE_BITS-1:0];
            assign in_hi  = i_range_high[VALUE_BITS-1:0];
            assign in_key = i_search_key[VALUE_BITS-1:0];
        end else begin : g_wide
            assign in_lo  = {{(VALUE_BITS-32){1'b0}}, i_range_low};
            assign in_hi  = {{(VALUE_BITS-32){1'b0}}, i_range_high};
            assign in_key = {{(VALUE_BITS-32){1'b0}}, i_search_key};
        end
    endgenerate

    assign ext_lo  = signed'({in_lo[VALUE_BITS-1], in_lo});
    assign ext_hi  = signed'({in_hi[VALUE_BITS-1], in_hi});
    assign ext_key = signed'({in_key[VALUE_BITS-1], in_key});

    // Two table banks: read the live one, build into the other.
    logic                    wr_en;
    logic [2*VALUE_BITS-1:0] wr_data;
    logic [AW-1:0]           rd_addr;
    logic [2*VALUE_BITS-1:0] bank_q [2];
    logic [2*VALUE_BITS-1:0] rd_q;

    generate
        for (genvar g = 0; g < 2; g++) begin : g_bank
            dise_ram #(
                .WIDTH (2 * VALUE_BITS),
                .DEPTH (CAPACITY)
            ) u_ram (
                .i_clk     (i_clk),
                .i_wr_en   (wr_en && (r_bank != 1'(g))),
                .i_wr_addr (r_n[AW-1:0]),
                .i_wr_data (wr_data),
                .i_rd_addr (rd_addr),
                .o_rd_data (bank_q[g])
            );
        end
    endgenerate

    assign rd_q = bank_q[r_bank];

    // Stored entry, widened by one bit.
    logic signed [W-1:0] ent_lo, ent_hi, lo_m1, hi_p1;
    assign ent_lo = signed'({rd_q[VALUE_BITS-1], rd_q[VALUE_BITS-1:0]});
    assign ent_hi = signed'({rd_q[2*VALUE_BITS-1], rd_q[2*VALUE_BITS-1:VALUE_BITS]});
    assign lo_m1  = r_lo - W'(1);
    assign hi_p1  = r_hi + W'(1);

    // Write emission request from the sequencer.
    logic                em_do, em_full;
    logic signed [W-1:0] em_lo, em_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_bank  <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_i      <= n_i;
        r_n      <= n_n;
        r_placed <= n_placed;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_p2_lo  <= n_p2_lo;
        r_p2_hi  <= n_p2_hi;
        r_status <= n_status;
        r_hit    <= n_hit;
        r_hlo    <= n_hlo;
        r_hhi    <= n_hhi;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_bank   = r_bank;
        n_op     = r_op;
        n_i      = r_i;
        n_n      = r_n;
        n_placed = r_placed;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_p2_lo  = r_p2_lo;
        n_p2_hi  = r_p2_hi;
        n_status = r_status;
        n_hit    = r_hit;
        n_hlo    = r_hlo;
        n_hhi    = r_hhi;
        em_do    = 1'b0;
        em_lo    = r_lo;
        em_hi    = r_hi;
        rd_addr  = r_i[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op     = t_op'(i_operation);
                    n_i      = '0;
                    n_n      = '0;
                    n_placed = 1'b0;
                    n_hit    = 1'b0;
                    n_hlo    = '0;
                    n_hhi    = '0;
                    n_status = STAT_OK;
                    n_lo     = ext_lo;
                    n_hi     = ext_hi;
                    case (t_op'(i_operation))
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = ST_DONE;
                        end
                        OP_FIND: begin
                            n_lo    = ext_key;
                            n_state = ST_RD;
                        end
                        default: begin
                            if (ext_hi < ext_lo) begin
                                n_status = STAT_INVALID;
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                    endcase
                end
            end
            ST_RD: begin
                // Issue the read of entry r_i, or finish the scan.
                if (r_i == r_count) begin
                    n_state = (r_op == OP_FIND) ? ST_DONE : ST_TAIL;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_i     = r_i + NW'(1);
                n_state = ST_RD;
                case (r_op)
                    OP_FIND: begin
                        if (ent_lo <= r_lo && r_lo <= ent_hi) begin
                            n_hit   = 1'b1;
                            n_hlo   = ent_lo;
                            n_hhi   = ent_hi;
                            n_state = ST_DONE;
                        end
                    end
                    OP_INSERT: begin
                        if (ent_hi < lo_m1) begin
                            em_do = 1'b1;
                            em_lo = ent_lo;
                            em_hi = ent_hi;
                        end else if (ent_lo > hi_p1) begin
                            em_do = 1'b1;
                            if (!r_placed) begin
                                n_placed = 1'b1;
                                n_p2_lo  = ent_lo;
                                n_p2_hi  = ent_hi;
                                n_state  = ST_EMIT2;
                            end else begin
                                em_lo = ent_lo;
                                em_hi = ent_hi;
                            end
                        end else begin
                            if (ent_lo < r_lo) n_lo = ent_lo;
                            if (ent_hi > r_hi) n_hi = ent_hi;
                        end
                    end
                    default: begin
                        // Erase: keep, drop, trim or split the entry.
                        if (ent_hi < r_lo || ent_lo > r_hi) begin
                            em_do = 1'b1;
                            em_lo = ent_lo;
                            em_hi = ent_hi;
                        end else if (ent_lo < r_lo) begin
                            em_do = 1'b1;
                            em_lo = ent_lo;
                            em_hi = lo_m1;
                            if (ent_hi > r_hi) begin
                                n_p2_lo = hi_p1;
                                n_p2_hi = ent_hi;
                                n_state = ST_EMIT2;
                            end
                        end else if (ent_hi > r_hi) begin
                            em_do = 1'b1;
                            em_lo = hi_p1;
                            em_hi = ent_hi;
                        end
                    end
                endcase
            end
            ST_EMIT2: begin
                em_do   = 1'b1;
                em_lo   = r_p2_lo;
                em_hi   = r_p2_hi;
                n_state = ST_RD;
            end
            ST_TAIL: begin
                // Place the range if nothing above it did, then commit.
                em_do   = (r_op == OP_INSERT) && !r_placed;
                n_bank  = ~r_bank;
                n_count = r_n + NW'(em_do);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Drop the command if the rebuilt table would overflow.
        em_full = em_do && (r_n == NW'(CAPACITY));
        if (em_full) begin
            n_status = STAT_FULL;
            n_state  = ST_DONE;
            n_bank   = r_bank;
            n_count  = r_count;
        end else if (em_do) begin
            n_n = r_n + NW'(1);
        end
    end

    assign wr_en   = em_do && !em_full;
    assign wr_data = {em_hi[VALUE_BITS-1:0], em_lo[VALUE_BITS-1:0]};

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = (r_state == ST_DONE);
    assign o_status   = r_status;
    assign o_hit      = r_hit;
    assign o_hit_low  = 32'(r_hlo);
    assign o_hit_high = 32'(r_hhi);

    `DISE_ASSERT_IMP(a_wr_in_range, i_clk, i_rst_n, wr_en, r_n < NW'(CAPACITY), "write past capacity")
    `DISE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= NW'(CAPACITY), "count overflow")
    `DISE_ASSERT_NXT(a_commit_swap, i_clk, i_rst_n, (r_state == ST_TAIL) && !em_full, r_bank != $past(r_bank), "bank not swapped")
    `DISE_ASSERT_NXT(a_full_keeps, i_clk, i_rst_n, em_full, (r_count == $past(r_count)) && (r_bank == $past(r_bank)), "full changed table")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import dise_pkg::*;

    localparam int CAP = 64;
    localparam int MAX_CYCLES = 1500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = OP_FIND;
    logic signed [31:0] i_range_low = '0;
    logic signed [31:0] i_range_high = '0;
    logic signed [31:0] i_search_key = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic        o_hit;
    logic signed [31:0] o_hit_low;
    logic signed [31:0] o_hit_high;

    disjoint_interval_set_engine DUT (.*);

    always #4 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0]         status;
        logic               hit;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_reply;

    // Shadow copy of the interval table, kept sorted and disjoint.
    longint set_lo[$];
    longint set_hi[$];
    t_reply pending_replies[$];

    int  mismatches = 0;
    int  replies_seen = 0;
    int  cycles = 0;
    int  sent = 0;
    int  n_full = 0, n_hits = 0, n_split = 0;
    bit  sender_gaps = 1'b1;
    bit  sink_gaps = 1'b1;

    // Apply one command to the shadow table and return the reply it earns.
    function automatic t_reply apply_command(logic [1:0] op, logic signed [31:0] rl,
                                             logic signed [31:0] rh,
                                             logic signed [31:0] key);
        t_reply r;
        longint lo, hi, a, b;
        longint nlo[$];
        longint nhi[$];
        bit placed;
        r = '0;
        lo = rl;
        hi = rh;
        placed = 1'b0;
        case (op)
            OP_INSERT, OP_ERASE: begin
                if (hi < lo) begin
                    r.status = STAT_INVALID;
                    return r;
                end
                foreach (set_lo[i]) begin
                    a = set_lo[i];
                    b = set_hi[i];
                    if (op == OP_INSERT) begin
                        if (b < lo - 1) begin
                            nlo.push_back(a); nhi.push_back(b);
                        end else if (a > hi + 1) begin
                            if (!placed) begin
                                nlo.push_back(lo); nhi.push_back(hi);
                                placed = 1'b1;
                            end
                            nlo.push_back(a); nhi.push_back(b);
                        end else begin
                            if (a < lo) lo = a;
                            if (b > hi) hi = b;
                        end
                    end else if (b < lo || a > hi) begin
                        nlo.push_back(a); nhi.push_back(b);
                    end else begin
                        if (a < lo) begin
                            nlo.push_back(a); nhi.push_back(lo - 1);
                        end
                        if (b > hi) begin
                            nlo.push_back(hi + 1); nhi.push_back(b);
                        end
                        if (a < lo && b > hi) n_split++;
                    end
                end
                if (op == OP_INSERT && !placed) begin
                    nlo.push_back(lo); nhi.push_back(hi);
                end
                if (nlo.size() > CAP) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    set_lo = nlo;
                    set_hi = nhi;
                end
            end
            OP_FIND: begin
                foreach (set_lo[i]) begin
                    if (set_lo[i] <= key && key <= set_hi[i]) begin
                        r.hit = 1'b1;
                        r.lo = set_lo[i][31:0];
                        r.hi = set_hi[i][31:0];
                        n_hits++;
                        break;
                    end
                end
            end
            default: begin
                set_lo.delete();
                set_hi.delete();
            end
        endcase
        return r;
    endfunction

    // Send one transaction; the prediction is queued at acceptance.
    // Valid stays high after acceptance so back-to-back commands follow at once.
    task automatic send_cmd(logic [1:0] op, logic signed [31:0] rl,
                            logic signed [31:0] rh, logic signed [31:0] key);
        int gap;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_range_low  <= rl;
        i_range_high <= rh;
        i_search_key <= key;
        do @(posedge i_clk); while (o_stall);
        pending_replies.push_back(apply_command(op, rl, rh, key));
        sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // Pick a bound near something already stored, so merges and trims happen.
    function automatic logic signed [31:0] near_bound();
        int k;
        longint v;
        if (set_lo.size() == 0 || $urandom_range(0, 5) == 0)
            return $urandom_range(0, 4000) - 2000;
        k = $urandom_range(0, set_lo.size() - 1);
        v = ($urandom_range(0, 1) ? set_lo[k] : set_hi[k]) + $urandom_range(0, 4) - 2;
        if (v > 32'sh7fffffff) v = 32'sh7fffffff;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic random_cmd();
        logic [1:0] op;
        logic signed [31:0] a, b, t;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) op = OP_INSERT;
        else if (sel < 65) op = OP_ERASE;
        else if (sel < 99) op = OP_FIND;
        else op = OP_CLEAR;
        if ($urandom_range(0, 19) == 0) begin
            // raw full-range noise, often inverted
            a = $urandom();
            b = $urandom();
        end else begin
            a = near_bound();
            b = a + $urandom_range(0, 60);
            if (b < a) b = 32'sh7fffffff;
            if ($urandom_range(0, 24) == 0) begin
                t = a; a = b; b = t;
            end
        end
        send_cmd(op, a, b, ($urandom_range(0, 3) == 0) ? $urandom() : near_bound());
    endtask

    task automatic test_directed();
        send_cmd(OP_FIND, 0, 0, 0);                      // empty table miss
        send_cmd(OP_INSERT, 32'sh80000000, 32'sh80000000, 0);
        send_cmd(OP_INSERT, 32'sh7fffffff, 32'sh7fffffff, 0);
        send_cmd(OP_FIND, 0, 0, 32'sh80000000);
        send_cmd(OP_FIND, 0, 0, 32'sh7fffffff);
        send_cmd(OP_INSERT, 10, 20, 0);
        send_cmd(OP_INSERT, 21, 30, 0);                  // touching merge
        send_cmd(OP_INSERT, 12, 15, 0);                  // already covered
        send_cmd(OP_ERASE, 14, 16, 0);                   // split
        send_cmd(OP_FIND, 0, 0, 13);
        send_cmd(OP_FIND, 0, 0, 15);
        send_cmd(OP_INSERT, 5, 3, 0);                    // upper below lower
        send_cmd(OP_ERASE, -1, -2, 0);
        send_cmd(OP_FIND, 5, 3, 17);
        send_cmd(OP_ERASE, 32'sh80000000, 32'sh7fffffff, 0);
        send_cmd(OP_INSERT, 32'sh80000000, 32'sh7fffffff, 0);
        send_cmd(OP_FIND, 0, 0, 32'sh5a5aa5a5);
        send_cmd(OP_ERASE, 0, 0, 0);
        send_cmd(OP_FIND, 0, 0, 32'shffffffff);
        send_cmd(OP_CLEAR, 32'shffffffff, 0, 32'shffffffff);
        send_cmd(OP_FIND, 0, 0, 1);
    endtask

    // Fill the table to capacity with gapped two-value ranges, then overflow it.
    task automatic test_capacity();
        send_cmd(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < CAP; i++) send_cmd(OP_INSERT, i * 4, i * 4 + 1, 0);
        send_cmd(OP_INSERT, 1000, 1000, 0);              // one too many
        send_cmd(OP_ERASE, 0, 0, 0);                     // trim keeps count
        send_cmd(OP_ERASE, 8, 8, 0);
        send_cmd(OP_INSERT, 2, 2, 0);                    // touching merge keeps count
        send_cmd(OP_ERASE, 20, 20, 0);
        send_cmd(OP_FIND, 0, 0, 21);
        // hold off until the engine is fully drained
        wait_drained();
        send_cmd(OP_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i == count - 300) begin
                sender_gaps = 1'b0;
                sink_gaps = 1'b0;
            end
            random_cmd();
        end
    endtask

    // Result side: random stall bursts, compare at each accepted result.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                exp_r = pending_replies.pop_front();
                if (o_status !== exp_r.status || o_hit !== exp_r.hit ||
                    o_hit_low !== exp_r.lo || o_hit_high !== exp_r.hi) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp st=%0d hit=%0d [%0d,%0d] got st=%0d hit=%0d [%0d,%0d]",
                                 replies_seen, exp_r.status, exp_r.hit, exp_r.lo, exp_r.hi,
                                 o_status, o_hit, o_hit_low, o_hit_high);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 12);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_random(1850);
        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("%0d commands, %0d results: %0d find hits, %0d splits, %0d full rejects",
                 sent, replies_seen, n_hits, n_split, n_full);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
